// ===== rtl/dlc_pkg.sv =====
`default_nettype none
package dlc_pkg;

  // Default number of fraction bits in the texture coordinates.
  localparam int COORD_FRAC_BITS_DEF = 16;

  // Number of CORDIC micro-rotations in each vectoring datapath.
  localparam int CORDIC_STEPS = 28;

  // Number of result bits from the square root.
  localparam int SQRT_STEPS = 32;

  // Number of quotient bits from the density divider.
  localparam int DIV_STEPS = 32;

  // Datapath widths.
  localparam int CW = 36;  // CORDIC x and y, signed
  localparam int PAW = 34;  // polar angle accumulator, signed

  // About 2^64 / (2 pi^2), the density numerator.
  localparam logic [59:0] DENSITY_NUM = 60'd934522971947765885;

  // Arctangent of 2^-i, in units of 2^32 per full turn.
  localparam logic [31:0] TURN_TAB [0:CORDIC_STEPS-1] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
    32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
    32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304,
    32'd652, 32'd326, 32'd163, 32'd81,
    32'd41, 32'd20, 32'd10, 32'd5
  };

endpackage
`default_nettype wire

// ===== rtl/direction_to_latlong_coords.sv =====
`default_nettype none
// Equirectangular mapping of a unit direction to texture coordinates.
// An item (dir_x, dir_y, dir_z, signed Q1.15) is taken at a rising edge
// where start is high and busy is low. Busy is always low: the block is a
// fully pipelined datapath and takes one item every cycle.
// The result (coord_s, coord_t, density) shows on the result ports for one
// cycle, marked by done, after the input, preparation, square-root,
// prescale, divider and output registers; results leave in item order.
// The longest path is the chain of a 32-stage square root for sin theta,
// followed by a prescale stage and a 32-stage restoring divider for the
// density. The azimuth CORDIC runs beside the square root, the polar one
// beside the divider (28 stages each); their results wait in delay lines.
// Reset clears every valid bit; items in flight are dropped and done stays
// low until new items come out. The receiver cannot stall, so nothing
// ever waits inside the block.
module direction_to_latlong_coords #(
  parameter int COORD_FRAC_BITS = dlc_pkg::COORD_FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] dir_x,
  input  wire logic signed [15:0] dir_y,
  input  wire logic signed [15:0] dir_z,
  output logic                    done,
  output logic [15:0]             coord_s,
  output logic [16:0]             coord_t,
  output logic [31:0]             density
);

  localparam int F = COORD_FRAC_BITS;
  localparam int NA = dlc_pkg::CORDIC_STEPS;
  localparam int NS = dlc_pkg::SQRT_STEPS;
  localparam int ND = dlc_pkg::DIV_STEPS;
  localparam int CW = dlc_pkg::CW;
  localparam int PAW = dlc_pkg::PAW;
  // Register index of the last divider stage.
  localparam int LAST = 2 + NS + 1 + ND - 1;
  // Stages that the azimuth waits after its CORDIC ends.
  localparam int S_LEN = LAST - (2 + NA) + 1;
  // Stages that the polar fraction waits after its CORDIC ends.
  localparam int T_LEN = LAST - (2 + NS + NA) + 1;
  localparam logic [32:0] S_RND = 33'(1) << (31 - F);
  localparam logic [32:0] T_RND = 33'(1) << (30 - F);

  assign busy = 1'b0;

  // Valid bits, one per register stage.
  logic vld [0:LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n <= LAST; n++) vld[n] <= 1'b0;
      done <= 1'b0;
    end else begin
      vld[0] <= start;
      for (int n = 1; n <= LAST; n++) vld[n] <= vld[n-1];
      done <= vld[LAST];
    end
  end

  // Input registers.
  logic signed [15:0] in_x, in_y, in_z;

  always_ff @(posedge clk) begin
    in_x <= dir_x;
    in_y <= dir_y;
    in_z <= dir_z;
  end

  // Preparation: 1 - z^2 for the square root, and the azimuth start
  // vector folded into the right half plane.
  logic signed [31:0] zz;
  logic signed [CW-1:0] ax_ext, ay_ext;
  logic [31:0] p1_w;
  logic signed [CW-1:0] p1_ax, p1_ay;
  logic [31:0] p1_aa;
  logic p1_nz;
  logic signed [15:0] p1_z;

  assign zz = in_z * in_z;
  assign ax_ext = CW'(in_x) <<< 16;
  assign ay_ext = CW'(in_y) <<< 16;

  always_ff @(posedge clk) begin
    p1_w <= 32'h4000_0000 - 32'(zz);
    p1_nz <= (in_x != 16'sd0) || (in_y != 16'sd0);
    p1_z <= in_z;
    if (in_x[15]) begin
      p1_ax <= -ax_ext;
      p1_ay <= -ay_ext;
      p1_aa <= 32'h8000_0000;
    end else begin
      p1_ax <= ax_ext;
      p1_ay <= ay_ext;
      p1_aa <= 32'h0000_0000;
    end
  end

  // Square root of (1 - z^2) << 32, one result bit per stage.
  logic [35:0] sq_rem [0:NS-1];
  logic [31:0] sq_q [0:NS-1];
  logic [31:0] sq_w [0:NS-1];
  logic signed [15:0] sq_z [0:NS-1];

  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    logic [35:0] rem_in, rn, tr;
    logic [31:0] q_in, w_in;
    logic signed [15:0] z_in;
    logic [1:0] pair;

    if (k == 0) begin : g_src
      assign rem_in = '0;
      assign q_in = '0;
      assign w_in = p1_w;
      assign z_in = p1_z;
    end else begin : g_src
      assign rem_in = sq_rem[k-1];
      assign q_in = sq_q[k-1];
      assign w_in = sq_w[k-1];
      assign z_in = sq_z[k-1];
    end

    // The radicand's low half is zero, so only the first 16 pairs carry bits.
    if (k < 16) begin : g_pair
      assign pair = w_in[31-2*k -: 2];
    end else begin : g_pair
      assign pair = 2'b00;
    end

    assign rn = {rem_in[33:0], pair};
    assign tr = {2'b00, q_in, 2'b01};

    always_ff @(posedge clk) begin
      sq_w[k] <= w_in;
      sq_z[k] <= z_in;
      if (rn >= tr) begin
        sq_rem[k] <= rn - tr;
        sq_q[k] <= {q_in[30:0], 1'b1};
      end else begin
        sq_rem[k] <= rn;
        sq_q[k] <= {q_in[30:0], 1'b0};
      end
    end
  end

  // Azimuth CORDIC in vectoring mode, one micro-rotation per stage.
  logic signed [CW-1:0] az_x [0:NA-1];
  logic signed [CW-1:0] az_y [0:NA-1];
  logic [31:0] az_a [0:NA-1];
  logic az_nz [0:NA-1];

  for (genvar i = 0; i < NA; i++) begin : g_az
    logic signed [CW-1:0] x_in, y_in;
    logic [31:0] a_in;
    logic nz_in;

    if (i == 0) begin : g_src
      assign x_in = p1_ax;
      assign y_in = p1_ay;
      assign a_in = p1_aa;
      assign nz_in = p1_nz;
    end else begin : g_src
      assign x_in = az_x[i-1];
      assign y_in = az_y[i-1];
      assign a_in = az_a[i-1];
      assign nz_in = az_nz[i-1];
    end

    always_ff @(posedge clk) begin
      az_nz[i] <= nz_in;
      if (!y_in[CW-1]) begin
        az_x[i] <= x_in + (y_in >>> i);
        az_y[i] <= y_in - (x_in >>> i);
        az_a[i] <= a_in + dlc_pkg::TURN_TAB[i];
      end else begin
        az_x[i] <= x_in - (y_in >>> i);
        az_y[i] <= y_in + (x_in >>> i);
        az_a[i] <= a_in - dlc_pkg::TURN_TAB[i];
      end
    end
  end

  // Round the azimuth to the coordinate fraction; wrap at one.
  logic [32:0] s_sum;
  logic [F-1:0] s_frac;
  logic [15:0] s_line [0:S_LEN-1];

  assign s_sum = {1'b0, az_a[NA-1]} + S_RND;
  assign s_frac = s_sum[31 -: F];

  always_ff @(posedge clk) begin
    s_line[0] <= az_nz[NA-1] ? 16'(s_frac) : 16'd0;
    for (int n = 1; n < S_LEN; n++) s_line[n] <= s_line[n-1];
  end

  // Polar CORDIC on (sin theta, -z), angle starting at a quarter turn.
  logic signed [CW-1:0] pl_x [0:NA-1];
  logic signed [CW-1:0] pl_y [0:NA-1];
  logic signed [PAW-1:0] pl_a [0:NA-1];

  for (genvar i = 0; i < NA; i++) begin : g_pl
    logic signed [CW-1:0] x_in, y_in;
    logic signed [PAW-1:0] a_in, t_ext;

    if (i == 0) begin : g_src
      assign x_in = CW'({1'b0, sq_q[NS-1]});
      assign y_in = -(CW'(sq_z[NS-1]) <<< 16);
      assign a_in = PAW'(32'h4000_0000);
    end else begin : g_src
      assign x_in = pl_x[i-1];
      assign y_in = pl_y[i-1];
      assign a_in = pl_a[i-1];
    end

    assign t_ext = PAW'(dlc_pkg::TURN_TAB[i]);

    always_ff @(posedge clk) begin
      if (!y_in[CW-1]) begin
        pl_x[i] <= x_in + (y_in >>> i);
        pl_y[i] <= y_in - (x_in >>> i);
        pl_a[i] <= a_in + t_ext;
      end else begin
        pl_x[i] <= x_in - (y_in >>> i);
        pl_y[i] <= y_in + (x_in >>> i);
        pl_a[i] <= a_in - t_ext;
      end
    end
  end

  // Clamp the polar angle to [0, half turn] and round to the fraction.
  logic signed [PAW-1:0] ang;
  logic [31:0] ang_c;
  logic [32:0] t_sum;
  logic [F+1:0] t_frac;
  logic [16:0] t_line [0:T_LEN-1];

  assign ang = pl_a[NA-1];

  always_comb begin
    if (ang[PAW-1]) begin
      ang_c = 32'd0;
    end else if (ang > PAW'(33'h0_8000_0000)) begin
      ang_c = 32'h8000_0000;
    end else begin
      ang_c = ang[31:0];
    end
  end

  assign t_sum = {1'b0, ang_c} + T_RND;
  assign t_frac = t_sum[32 -: F+2];

  always_ff @(posedge clk) begin
    t_line[0] <= 17'(t_frac);
    for (int n = 1; n < T_LEN; n++) t_line[n] <= t_line[n-1];
  end

  // Density prescale: floor((C + D/2) / D) with D = r << 17 equals
  // floor(((C + (r << 16)) >> 17) / r).
  logic [59:0] num_full;
  logic [42:0] num;
  logic [31:0] dv0_r;
  logic [32:0] dv0_p;
  logic [31:0] dv0_low;
  logic dv0_sat, dv0_zero;

  assign num_full = dlc_pkg::DENSITY_NUM + 60'({sq_q[NS-1], 16'd0});
  assign num = num_full[59:17];

  always_ff @(posedge clk) begin
    dv0_r <= sq_q[NS-1];
    dv0_p <= 33'(num[42:32]);
    dv0_low <= num[31:0];
    dv0_sat <= 32'(num[42:32]) >= sq_q[NS-1];
    dv0_zero <= sq_q[NS-1] == 32'd0;
  end

  // Restoring divider, one quotient bit per stage.
  logic [32:0] dv_p [0:ND-1];
  logic [31:0] dv_low [0:ND-1];
  logic [31:0] dv_q [0:ND-1];
  logic [31:0] dv_r [0:ND-1];
  logic dv_sat [0:ND-1];
  logic dv_zero [0:ND-1];

  for (genvar j = 0; j < ND; j++) begin : g_div
    logic [32:0] p_in, p_sh;
    logic [31:0] low_in, q_in, r_in;
    logic sat_in, zero_in;

    if (j == 0) begin : g_src
      assign p_in = dv0_p;
      assign low_in = dv0_low;
      assign q_in = '0;
      assign r_in = dv0_r;
      assign sat_in = dv0_sat;
      assign zero_in = dv0_zero;
    end else begin : g_src
      assign p_in = dv_p[j-1];
      assign low_in = dv_low[j-1];
      assign q_in = dv_q[j-1];
      assign r_in = dv_r[j-1];
      assign sat_in = dv_sat[j-1];
      assign zero_in = dv_zero[j-1];
    end

    assign p_sh = {p_in[31:0], low_in[31]};

    always_ff @(posedge clk) begin
      dv_low[j] <= {low_in[30:0], 1'b0};
      dv_r[j] <= r_in;
      dv_sat[j] <= sat_in;
      dv_zero[j] <= zero_in;
      if (p_sh >= {1'b0, r_in}) begin
        dv_p[j] <= p_sh - {1'b0, r_in};
        dv_q[j] <= {q_in[30:0], 1'b1};
      end else begin
        dv_p[j] <= p_sh;
        dv_q[j] <= {q_in[30:0], 1'b0};
      end
    end
  end

  // Output registers.
  always_ff @(posedge clk) begin
    coord_s <= s_line[S_LEN-1];
    coord_t <= t_line[T_LEN-1];
    if (dv_zero[ND-1]) begin
      density <= 32'd0;
    end else if (dv_sat[ND-1]) begin
      density <= 32'hFFFF_FFFF;
    end else begin
      density <= dv_q[ND-1];
    end
  end

endmodule
`default_nettype wire
